/* design/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/gas_pkg.sv */
package gas_pkg;

    localparam int NODES_DEF      = 256;
    localparam int MAX_DEGREE_DEF = 16;
    localparam int COST_BITS_DEF  = 16;

    localparam int STATUS_W = 3;

    localparam logic [STATUS_W-1:0] ST_NEIGHBOR = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ADDED    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

    // controller -> datapath
    typedef struct packed {
        logic                capture;      // latch the input transaction
        logic                clear_en;     // clear one degree entry
        logic                rd_sel_b;     // degree read at node_b
        logic                lat_da;
        logic                lat_db;
        logic                write_a;      // store entry in node_a's list
        logic                write_b;      // store entry in node_b's list
        logic                idx_inc;
        logic                load_nb;      // output <= neighbor entry
        logic                load_single;  // output <= single status result
        logic [STATUS_W-1:0] single_code;
    } gas_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clear_done;
        logic is_query;
        logic range_a;
        logic range_ab;
        logic full;
        logic deg_zero;
        logic self_loop;
        logic more;
    } gas_status_t;

endpackage

/* design/gas_ctrl.sv */
module gas_ctrl import gas_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    output logic        m_valid,
    input  logic        m_ready,
    input  gas_status_t status,
    output gas_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_CHECK_B,
        S_WRITE_B,
        S_Q_READ,
        S_Q_LOAD,
        S_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_OUT);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: begin
                cmd.clear_en = 1'b1;
                if (status.clear_done) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK: begin
                // degree of node_a is on the read port now
                cmd.lat_da   = 1'b1;
                cmd.rd_sel_b = 1'b1;
                if (!status.is_query) begin
                    state_next = S_CHECK_B;
                end else if (status.range_a) begin
                    cmd.load_single = 1'b1;
                    cmd.single_code = ST_RANGE;
                    state_next      = S_OUT;
                end else if (status.deg_zero) begin
                    cmd.load_single = 1'b1;
                    cmd.single_code = ST_EMPTY;
                    state_next      = S_OUT;
                end else begin
                    state_next = S_Q_READ;
                end
            end
            S_CHECK_B: begin
                cmd.lat_db = 1'b1;
                if (status.range_ab) begin
                    cmd.load_single = 1'b1;
                    cmd.single_code = ST_RANGE;
                    state_next      = S_OUT;
                end else if (status.full) begin
                    cmd.load_single = 1'b1;
                    cmd.single_code = ST_FULL;
                    state_next      = S_OUT;
                end else begin
                    cmd.write_a = 1'b1;
                    state_next  = S_WRITE_B;
                end
            end
            S_WRITE_B: begin
                cmd.write_b     = !status.self_loop;
                cmd.load_single = 1'b1;
                cmd.single_code = ST_ADDED;
                state_next      = S_OUT;
            end
            S_Q_READ: begin
                state_next = S_Q_LOAD;
            end
            S_Q_LOAD: begin
                cmd.load_nb = 1'b1;
                state_next  = S_OUT;
            end
            S_OUT: begin
                if (m_ready) begin
                    if (status.more) begin
                        cmd.idx_inc = 1'b1;
                        state_next  = S_Q_READ;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* design/gas_datapath.sv */
module gas_datapath import gas_pkg::*; #(
    parameter  int NODES      = NODES_DEF,
    parameter  int MAX_DEGREE = MAX_DEGREE_DEF,
    parameter  int COST_BITS  = COST_BITS_DEF,
    localparam int NODE_W     = $clog2(NODES),
    localparam int CNT_W      = NODE_W + 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  gas_cmd_t             cmd,
    output gas_status_t          status,
    input  logic                 s_req_type,
    input  logic [NODE_W-1:0]    s_node_a,
    input  logic [NODE_W-1:0]    s_node_b,
    input  logic [COST_BITS-1:0] s_edge_cost,
    input  logic                 cfg_wr_en,
    input  logic [CNT_W-1:0]     cfg_wr_data,
    output logic [NODE_W-1:0]    m_neighbor_node,
    output logic [COST_BITS-1:0] m_neighbor_cost,
    output logic                 m_is_last,
    output logic [STATUS_W-1:0]  m_status
);

    localparam int DEG_W    = $clog2(MAX_DEGREE + 1);
    localparam int SLOT_W   = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
    localparam int ADDR_W   = NODE_W + SLOT_W;
    localparam int ENTRY_W  = NODE_W + COST_BITS;
    localparam int NB_DEPTH = NODES * (2 ** SLOT_W);

    localparam logic [DEG_W-1:0] DEG_MAX  = DEG_W'(MAX_DEGREE);
    localparam logic [CNT_W-1:0] NODE_LIM = CNT_W'(NODES);

    logic [DEG_W-1:0]   deg_mem [NODES];
    logic [ENTRY_W-1:0] nb_mem  [NB_DEPTH];

    logic                 req_reg;
    logic [NODE_W-1:0]    a_reg;
    logic [NODE_W-1:0]    b_reg;
    logic [COST_BITS-1:0] cost_reg;
    logic [SLOT_W-1:0]    idx_reg;
    logic [DEG_W-1:0]     da_reg;
    logic [DEG_W-1:0]     db_reg;
    logic [CNT_W-1:0]     node_count_reg;
    logic [NODE_W-1:0]    clr_cnt_reg;
    logic [DEG_W-1:0]     deg_rdata_reg;
    logic [ENTRY_W-1:0]   nb_rdata_reg;

    logic [NODE_W-1:0]    out_node_reg;
    logic [COST_BITS-1:0] out_cost_reg;
    logic                 out_last_reg;
    logic [STATUS_W-1:0]  out_status_reg;

    logic [NODE_W-1:0]  deg_raddr;
    logic               deg_we;
    logic [NODE_W-1:0]  deg_waddr;
    logic [DEG_W-1:0]   deg_wdata;
    logic               nb_we;
    logic [ADDR_W-1:0]  nb_waddr;
    logic [ENTRY_W-1:0] nb_wdata;
    logic [ADDR_W-1:0]  nb_raddr;
    logic [CNT_W-1:0]   lim;
    logic               range_b;
    logic               last_flag;

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= NODE_LIM;
            clr_cnt_reg    <= '0;
            idx_reg        <= '0;
        end else begin
            if (cfg_wr_en) begin
                node_count_reg <= cfg_wr_data;
            end
            if (cmd.clear_en) begin
                clr_cnt_reg <= clr_cnt_reg + NODE_W'(1);
            end
            if (cmd.capture) begin
                idx_reg <= '0;
            end else if (cmd.idx_inc) begin
                idx_reg <= idx_reg + SLOT_W'(1);
            end
        end
    end

    // transaction fields and degree snapshots
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg  <= s_req_type;
            a_reg    <= s_node_a;
            b_reg    <= s_node_b;
            cost_reg <= s_edge_cost;
        end
        if (cmd.lat_da) begin
            da_reg <= deg_rdata_reg;
        end
        if (cmd.lat_db) begin
            db_reg <= deg_rdata_reg;
        end
    end

    // degree memory
    assign deg_raddr = cmd.rd_sel_b ? b_reg : s_node_a;
    assign deg_we    = cmd.clear_en | cmd.write_a | cmd.write_b;

    always_comb begin
        if (cmd.clear_en) begin
            deg_waddr = clr_cnt_reg;
            deg_wdata = '0;
        end else if (cmd.write_b) begin
            deg_waddr = b_reg;
            deg_wdata = db_reg + DEG_W'(1);
        end else begin
            deg_waddr = a_reg;
            deg_wdata = da_reg + DEG_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (deg_we) begin
            deg_mem[deg_waddr] <= deg_wdata;
        end
        deg_rdata_reg <= deg_mem[deg_raddr];
    end

    // neighbor memory, row per node, slot = list position
    assign nb_we    = cmd.write_a | cmd.write_b;
    assign nb_raddr = {a_reg, idx_reg};

    always_comb begin
        if (cmd.write_b) begin
            nb_waddr = {b_reg, db_reg[SLOT_W-1:0]};
            nb_wdata = {a_reg, cost_reg};
        end else begin
            nb_waddr = {a_reg, da_reg[SLOT_W-1:0]};
            nb_wdata = {b_reg, cost_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (nb_we) begin
            nb_mem[nb_waddr] <= nb_wdata;
        end
        nb_rdata_reg <= nb_mem[nb_raddr];
    end

    // output register
    assign last_flag = (DEG_W'(idx_reg) + DEG_W'(1)) == da_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_nb) begin
            out_node_reg   <= nb_rdata_reg[ENTRY_W-1:COST_BITS];
            out_cost_reg   <= nb_rdata_reg[COST_BITS-1:0];
            out_last_reg   <= last_flag;
            out_status_reg <= ST_NEIGHBOR;
        end else if (cmd.load_single) begin
            out_node_reg   <= '0;
            out_cost_reg   <= '0;
            out_last_reg   <= 1'b1;
            out_status_reg <= cmd.single_code;
        end
    end

    assign m_neighbor_node = out_node_reg;
    assign m_neighbor_cost = out_cost_reg;
    assign m_is_last       = out_last_reg;
    assign m_status        = out_status_reg;

    // status
    assign lim     = (node_count_reg > NODE_LIM) ? NODE_LIM : node_count_reg;
    assign range_b = {1'b0, b_reg} >= lim;

    assign status.clear_done = (clr_cnt_reg == NODE_W'(NODES - 1));
    assign status.is_query   = req_reg;
    assign status.range_a    = {1'b0, a_reg} >= lim;
    assign status.range_ab   = status.range_a | range_b;
    assign status.full       = (da_reg == DEG_MAX) || (deg_rdata_reg == DEG_MAX);
    assign status.deg_zero   = (deg_rdata_reg == '0);
    assign status.self_loop  = (a_reg == b_reg);
    assign status.more       = (out_status_reg == ST_NEIGHBOR) && !out_last_reg;

endmodule

/* design/graph_adjacency_store_top.sv */
// Undirected weighted graph held as one neighbor list per node. An add
// transaction (req_type 0) appends the edge to both endpoints' lists and
// returns one acknowledge (status 1); a self-loop is stored once, duplicates
// are stored again. A query transaction (req_type 1) streams every neighbor
// of node_a with its cost in insertion order, is_last on the final one; a
// node with no neighbors returns one status 2 result. Out-of-range nodes
// (at or beyond node_count, capped at NODES) give status 3, a full list
// status 4, and a rejected edge stores nothing. One transaction is handled
// at a time. The degree and neighbor RAMs have a registered read and each
// has a single write port. After reset the degree RAM is cleared, all NODES
// entries (256 by default), before s_ready rises; node_count may be written
// at any time, but only while no transaction is in flight.
`include "assert_macros.svh"

module graph_adjacency_store_top import gas_pkg::*; #(
    parameter  int NODES      = NODES_DEF,
    parameter  int MAX_DEGREE = MAX_DEGREE_DEF,
    parameter  int COST_BITS  = COST_BITS_DEF,
    localparam int NODE_W     = $clog2(NODES),
    localparam int CNT_W      = NODE_W + 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    // configuration: node_count
    input  logic                 cfg_wr_en,
    input  logic [CNT_W-1:0]     cfg_wr_data,

    // request channel
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_req_type,
    input  logic [NODE_W-1:0]    s_node_a,
    input  logic [NODE_W-1:0]    s_node_b,
    input  logic [COST_BITS-1:0] s_edge_cost,

    // result channel
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [NODE_W-1:0]    m_neighbor_node,
    output logic [COST_BITS-1:0] m_neighbor_cost,
    output logic                 m_is_last,
    output logic [STATUS_W-1:0]  m_status
);

    gas_cmd_t    cmd;
    gas_status_t status;

    // sequencer: clear sweep, checks, writes, result streaming
    gas_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // RAMs, transaction registers, range/fullness compare, output register
    gas_datapath #(
        .NODES      (NODES),
        .MAX_DEGREE (MAX_DEGREE),
        .COST_BITS  (COST_BITS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .s_req_type      (s_req_type),
        .s_node_a        (s_node_a),
        .s_node_b        (s_node_b),
        .s_edge_cost     (s_edge_cost),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .m_neighbor_node (m_neighbor_node),
        .m_neighbor_cost (m_neighbor_cost),
        .m_is_last       (m_is_last),
        .m_status        (m_status)
    );

    // one transaction in flight: never ready while a result is pending
    `ASSERT_NOW(a_one_in_flight, aclk, aresetn, 1'b1, !(s_ready && m_valid), "ready with result pending")

    // final result taken -> ready for the next transaction
    `ASSERT_NEXT(a_last_frees, aclk, aresetn, m_valid && m_ready && m_is_last, s_ready, "not ready after last")

    // a result never appears the cycle after acceptance (degree read first)
    `ASSERT_NEXT(a_accept_gap, aclk, aresetn, s_valid && s_ready, !m_valid && !s_ready, "result too early")

    // the two list writes of an add never share a cycle
    `ASSERT_NOW(a_write_order, aclk, aresetn, cmd.write_b, $past(cmd.write_a), "node_b write without node_a")

endmodule

/* verif/graph_adjacency_store_top_test.sv */
module graph_adjacency_store_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import gas_pkg::*;

    localparam int NODE_W        = $clog2(NODES_DEF);
    localparam int CNT_W         = NODE_W + 1;
    localparam int COST_W        = COST_BITS_DEF;
    localparam int CLK_HALF      = 5;
    // Longest legal quiet stretch is the degree clear after reset or the long
    // receiver hold-off (HOLD_CYCLES); this limit is several times either.
    localparam int STALL_LIMIT   = 2000;
    localparam int MAX_REPORTS   = 10;
    localparam int SETTLE_CYCLES = 10;
    localparam int DRAIN_CYCLES  = 20;
    localparam int HOLD_CYCLES   = 250;
    localparam int PHASE_ITEMS   = 26;

    localparam logic REQ_ADD   = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef struct {
        logic [NODE_W-1:0]   node;
        logic [COST_W-1:0]   cost;
        logic                last;
        logic [STATUS_W-1:0] status;
    } graph_result_t;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [CNT_W-1:0]     cfg_wr_data = '0;
    logic                 s_valid     = 1'b0;
    logic                 s_ready;
    logic                 s_req_type  = REQ_ADD;
    logic [NODE_W-1:0]    s_node_a    = '0;
    logic [NODE_W-1:0]    s_node_b    = '0;
    logic [COST_W-1:0]    s_edge_cost = '0;
    logic                 m_valid;
    logic                 m_ready     = 1'b0;
    logic [NODE_W-1:0]    m_neighbor_node;
    logic [COST_W-1:0]    m_neighbor_cost;
    logic                 m_is_last;
    logic [STATUS_W-1:0]  m_status;

    // Shadow copy of the graph: per-node degree and neighbor lists.
    int unsigned          node_degree [NODES_DEF];
    logic [NODE_W-1:0]    adj_node    [NODES_DEF][MAX_DEGREE_DEF];
    logic [COST_W-1:0]    adj_cost    [NODES_DEF][MAX_DEGREE_DEF];
    logic [CNT_W-1:0]     node_count_shadow;

    graph_result_t        awaited_results [$];

    int unsigned          mismatch_count  = 0;
    int unsigned          results_checked = 0;
    int unsigned          adds_sent       = 0;
    int unsigned          queries_sent    = 0;
    int unsigned          settings_used   = 0;

    // Idle controls shared between the test tasks, send_request and the result sink.
    bit                   src_steady  = 1'b0;
    bit                   sink_steady = 1'b0;
    int unsigned          sink_hold   = 0;

    graph_adjacency_store_top dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_node_a        (s_node_a),
        .s_node_b        (s_node_b),
        .s_edge_cost     (s_edge_cost),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_neighbor_node (m_neighbor_node),
        .m_neighbor_cost (m_neighbor_cost),
        .m_is_last       (m_is_last),
        .m_status        (m_status)
    );

    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    // node_count saturates at NODES; zero leaves no valid node at all.
    function automatic int unsigned node_limit();
        return (node_count_shadow > NODES_DEF) ? NODES_DEF : node_count_shadow;
    endfunction

    // Acks, errors and empty answers all look the same apart from status.
    function automatic void expect_single(input logic [STATUS_W-1:0] code);
        awaited_results.push_back('{node: '0, cost: '0, last: 1'b1, status: code});
    endfunction

    // Updates the shadow graph for one accepted transaction and queues what
    // the block should answer.
    function automatic void predict_request(input logic req,
                                            input logic [NODE_W-1:0] a,
                                            input logic [NODE_W-1:0] b,
                                            input logic [COST_W-1:0] cost);
        int unsigned   lim;
        int unsigned   da;
        int unsigned   db;
        graph_result_t entry;
        lim = node_limit();
        if (req == REQ_ADD) begin
            if (a >= lim || b >= lim) begin
                expect_single(ST_RANGE);
            end else if (node_degree[a] >= MAX_DEGREE_DEF ||
                         node_degree[b] >= MAX_DEGREE_DEF) begin
                expect_single(ST_FULL);
            end else begin
                da = node_degree[a];
                db = node_degree[b];
                adj_node[a][da] = b;
                adj_cost[a][da] = cost;
                node_degree[a]  = da + 1;
                // self-loop lands in one list only
                if (a != b) begin
                    adj_node[b][db] = a;
                    adj_cost[b][db] = cost;
                    node_degree[b]  = db + 1;
                end
                expect_single(ST_ADDED);
            end
        end else if (a >= lim) begin
            expect_single(ST_RANGE);
        end else if (node_degree[a] == 0) begin
            expect_single(ST_EMPTY);
        end else begin
            for (int i = 0; i < node_degree[a]; i++) begin
                entry.node   = adj_node[a][i];
                entry.cost   = adj_cost[a][i];
                entry.last   = (i + 1 == node_degree[a]);
                entry.status = ST_NEIGHBOR;
                awaited_results.push_back(entry);
            end
        end
    endfunction

    // Offers one transaction after a random gap (none while src_steady) and returns once it is taken.
    // s_valid is left high so a back-to-back transaction needs no dead cycle.
    task automatic send_request(input logic req,
                                input logic [NODE_W-1:0] a,
                                input logic [NODE_W-1:0] b,
                                input logic [COST_W-1:0] cost);
        int unsigned gap;
        gap = src_steady ? 0 : $urandom_range(0, 10);
        @(negedge aclk);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_req_type  <= req;
        s_node_a    <= a;
        s_node_b    <= b;
        s_edge_cost <= cost;
        do @(posedge aclk); while (!s_ready);
        predict_request(req, a, b, cost);
        if (req == REQ_ADD)
            adds_sent++;
        else
            queries_sent++;
    endtask

    task automatic source_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    // node_count only changes with nothing in flight; every transaction gives
    // at least one result, so an empty queue plus a short settle is enough.
    task automatic write_node_count(input logic [CNT_W-1:0] value);
        source_idle();
        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        node_count_shadow = value;
        settings_used++;
    endtask

    task automatic test_empty_and_extremes();
        write_node_count(9'd256);
        send_request(REQ_QUERY, 8'd0,   8'd0,   16'h0000);
        send_request(REQ_QUERY, 8'd255, 8'd0,   16'h0000);
        send_request(REQ_ADD,   8'd0,   8'd255, 16'hFFFF);
        send_request(REQ_ADD,   8'd255, 8'd0,   16'h0000);   // same edge again
        send_request(REQ_ADD,   8'd128, 8'd128, 16'h8000);   // self-loop
        send_request(REQ_ADD,   8'd1,   8'd254, 16'h5555);
        send_request(REQ_ADD,   8'd254, 8'd1,   16'hAAAA);
        send_request(REQ_QUERY, 8'd0,   8'd0,   16'h0000);
        send_request(REQ_QUERY, 8'd255, 8'd0,   16'h0000);
        send_request(REQ_QUERY, 8'd128, 8'd0,   16'h0000);
        send_request(REQ_QUERY, 8'd254, 8'd0,   16'h0000);
        // node_b and cost carry junk; a query must ignore them
        send_request(REQ_QUERY, 8'd1,   8'd255, 16'hFFFF);
    endtask

    task automatic test_range_limits();
        write_node_count(9'd0);
        send_request(REQ_ADD,   8'd0, 8'd0, 16'h1234);
        send_request(REQ_QUERY, 8'd0, 8'd0, 16'h0000);
        write_node_count(9'd1);
        send_request(REQ_ADD,   8'd0, 8'd0, 16'h00FF);
        send_request(REQ_ADD,   8'd0, 8'd1, 16'h0F0F);
        send_request(REQ_ADD,   8'd1, 8'd0, 16'hF0F0);
        send_request(REQ_QUERY, 8'd1, 8'd0, 16'h0000);
        send_request(REQ_QUERY, 8'd0, 8'd0, 16'h0000);
        // above NODES: behaves as NODES
        write_node_count(9'd511);
        send_request(REQ_ADD,   8'd255, 8'd254, COST_W'($urandom()));
        send_request(REQ_QUERY, 8'd255, 8'd0,   16'h0000);
    endtask

    task automatic test_full_list();
        write_node_count(9'd256);
        for (int i = 0; i < MAX_DEGREE_DEF; i++)
            send_request(REQ_ADD, 8'd200, 8'(210 + i), COST_W'($urandom()));
        send_request(REQ_ADD,   8'd200, 8'd226, 16'h0001);   // node_a full
        send_request(REQ_ADD,   8'd227, 8'd200, 16'h0002);   // node_b full
        send_request(REQ_QUERY, 8'd200, 8'd0,   16'h0000);
        // full and out of range at once: range wins
        write_node_count(9'd100);
        send_request(REQ_ADD,   8'd200, 8'd5,   16'h0003);
    endtask

    // Long receiver hold-off while long queries keep arriving, so the block
    // backs up and drops s_ready.
    task automatic test_output_backpressure();
        write_node_count(9'd256);
        src_steady = 1'b1;
        sink_hold  = HOLD_CYCLES;
        send_request(REQ_QUERY, 8'd200, 8'd0,   16'h0000);
        send_request(REQ_QUERY, 8'd200, 8'd0,   16'h0000);
        send_request(REQ_ADD,   8'd226, 8'd227, 16'hBEEF);
        send_request(REQ_QUERY, 8'd226, 8'd0,   16'h0000);
        send_request(REQ_ADD,   8'd200, 8'd1,   16'h0004);
        send_request(REQ_QUERY, 8'd200, 8'd0,   16'h0000);
        src_steady = 1'b0;
    endtask

    // Mostly in-range traffic so lists grow and fill; a small node_count
    // drives some nodes to full, a few wild node indices hit the range check.
    task automatic test_random_traffic();
        logic [CNT_W-1:0]  setting [4];
        logic              req;
        logic [NODE_W-1:0] a;
        logic [NODE_W-1:0] b;
        int unsigned       lim;
        setting[0] = 9'd256;
        setting[1] = 9'd3;
        setting[2] = 9'd12;
        setting[3] = CNT_W'($urandom_range(1, NODES_DEF));
        for (int p = 0; p < 4; p++) begin
            write_node_count(setting[p]);
            src_steady  = (p == 1);
            sink_steady = (p == 1) || (p == 3);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                lim = node_limit();
                req = ($urandom_range(0, 9) < 6) ? REQ_ADD : REQ_QUERY;
                a = ($urandom_range(0, 99) < 88) ? NODE_W'($urandom_range(0, lim - 1))
                                                 : NODE_W'($urandom());
                b = ($urandom_range(0, 99) < 88) ? NODE_W'($urandom_range(0, lim - 1))
                                                 : NODE_W'($urandom());
                send_request(req, a, b, COST_W'($urandom()));
            end
        end
        src_steady  = 1'b0;
        sink_steady = 1'b0;
    endtask

    // Result side: random stall per result (none while sink_steady), plus the one long hold-off.
    initial begin : result_sink
        int unsigned stall;
        @(negedge aclk);
        forever begin
            if (sink_hold != 0) begin
                m_ready <= 1'b0;
                repeat (sink_hold) @(negedge aclk);
                sink_hold = 0;
            end
            stall = sink_steady ? 0 : $urandom_range(0, 10);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    always @(posedge aclk) begin : result_check
        graph_result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_checked++;
            if (awaited_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: unexpected result node %0d cost %0h last %0b status %0d",
                             $realtime, m_neighbor_node, m_neighbor_cost, m_is_last,
                             m_status);
            end else begin
                want = awaited_results.pop_front();
                if (m_neighbor_node !== want.node || m_neighbor_cost !== want.cost ||
                    m_is_last !== want.last || m_status !== want.status) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display({"%0t: expected node %0d cost %0h last %0b status %0d,",
                                  " got node %0d cost %0h last %0b status %0d"},
                                 $realtime, want.node, want.cost, want.last, want.status,
                                 m_neighbor_node, m_neighbor_cost, m_is_last, m_status);
                end
            end
        end
    end

    // Ends the run if neither channel moves a transaction for too long.
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                 $realtime, STALL_LIMIT, awaited_results.size());
        $display("Mismatches found");
        $finish;
    end

    initial begin : test_sequence
        foreach (node_degree[i])
            node_degree[i] = 0;
        node_count_shadow = 9'd256;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        test_empty_and_extremes();
        test_range_limits();
        test_full_list();
        test_output_backpressure();
        test_random_traffic();

        source_idle();
        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d edge adds and %0d neighbor queries, %0d results checked,",
                 adds_sent, queries_sent, results_checked);
        $display("across %0d node_count writes incl. 0, 1, 256 and 511, full lists and stalls",
                 settings_used);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+design
design/gas_pkg.sv
design/gas_ctrl.sv
design/gas_datapath.sv
design/graph_adjacency_store_top.sv
verif/graph_adjacency_store_top_test.sv
